[sv/ddrb_pkg.sv]
// Shared types and constants for the disk drive register block.
package ddrb_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
    logic [17:0] image_index;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       mirror_valid;
    logic       mirror_select;
  } rsp_t;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_LOAD  = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_BLOCK = 2'd1;
  localparam logic [1:0] PH_CRC   = 2'd2;
  localparam logic [1:0] PH_END   = 2'd3;

  localparam logic [15:0] ADDR_RELOAD_LO = 16'h4020;
  localparam logic [15:0] ADDR_RELOAD_HI = 16'h4021;
  localparam logic [15:0] ADDR_TIMER_CTL = 16'h4022;
  localparam logic [15:0] ADDR_MASTER    = 16'h4023;
  localparam logic [15:0] ADDR_WDATA     = 16'h4024;
  localparam logic [15:0] ADDR_CONTROL   = 16'h4025;
  localparam logic [15:0] ADDR_STATUS    = 16'h4030;
  localparam logic [15:0] ADDR_RDATA     = 16'h4031;
  localparam logic [15:0] ADDR_DRIVE     = 16'h4032;
  localparam logic [15:0] ADDR_EXT       = 16'h4033;

  localparam logic [5:0] SPINUP_TICKS = 6'd50;

  localparam logic [2:0] CFG_SIDE     = 3'd0;
  localparam logic [2:0] CFG_INSERTED = 3'd1;
  localparam logic [2:0] CFG_PRESENT  = 3'd2;
  localparam logic [2:0] CFG_CPS      = 3'd3;
  localparam logic [2:0] CFG_CPB      = 3'd4;

endpackage

[sv/disk_drive_register_block_top.sv]
// Top level of the disk drive register block: registers, timer and byte stream.
// Flow: each accepted word passes S_EXEC and then S_DONE, which strobes its result word; a
// $4025 write that releases the transfer reset runs the block header parse in between. A tick
// runs S_TIMER once per timer expiry and then S_SPIN, and while bytes stream, S_BYTE for each
// byte, with a store read (S_BRD) per data byte and a header parse per block.
// Throughput: one word at a time; start is taken again in the cycle the result strobe is up,
// and the receiver cannot stall. Reset: asynchronous, clears all drive state but the scratch
// registers; the store keeps its contents.
module disk_drive_register_block_top #(
  parameter int SideSize = 65500,
  parameter int MaxSides = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  ddrb_pkg::req_t      req_i,
  output logic                done_o,
  output ddrb_pkg::rsp_t      rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int Depth = MaxSides * SideSize;
  localparam int AW    = $clog2(Depth);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_TIMER  = 4'd2;
  localparam logic [3:0] S_SPIN   = 4'd3;
  localparam logic [3:0] S_BYTE   = 4'd4;
  localparam logic [3:0] S_BRD    = 4'd5;  // store read in flight for a data byte
  localparam logic [3:0] S_EB     = 4'd6;  // start a block header parse
  localparam logic [3:0] S_EBT    = 4'd7;  // type byte arrives
  localparam logic [3:0] S_EB13   = 4'd8;  // header byte 13 arrives
  localparam logic [3:0] S_EB14   = 4'd9;  // header byte 14 arrives
  localparam logic [3:0] S_EBSZ   = 4'd10; // clip block size and enter it
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_q, state_d;
  ddrb_pkg::req_t req_q, req_d;
  ddrb_pkg::rsp_t rsp_q, rsp_d;
  logic done_q, done_d;
  // After a header parse, go back to the byte loop (1) or finish the write (0).
  logic eb_ret_q, eb_ret_d;

  // Configuration registers.
  logic [1:0] cur_side_q;
  logic       inserted_q, present_q;
  logic [9:0] cps_q, cpb_q;

  // Drive state.
  logic [15:0] reload_q, reload_d, count_q, count_d;
  logic        t_en_q, t_en_d, t_rep_q, t_rep_d, t_pend_q, t_pend_d;
  logic [1:0]  master_q, master_d;
  logic        motor_q, motor_d, xrst_q, xrst_d, rmode_q, rmode_d;
  logic        b_en_q, b_en_d, scan_q, scan_d;
  logic [15:0] pos_q, pos_d, bstart_q, bstart_d;
  logic [7:0]  rbuf_q, rbuf_d;
  logic        b_pend_q, b_pend_d, eoh_q, eoh_d;
  logic [10:0] acc_q, acc_d;
  logic [5:0]  spin_q, spin_d;
  logic [7:0]  staged_q, staged_d;
  logic [1:0]  phase_q, phase_d;
  logic [16:0] brem_q, brem_d;
  logic [1:0]  crem_q, crem_d;
  logic [15:0] nds_q, nds_d;
  logic [9:0]  trem_q, trem_d;   // cycles left in the current tick for the timer
  logic [7:0]  ebtype_q, ebtype_d;
  logic [7:0]  b13_q, b13_d;

  // Store ports.
  logic          st_we;
  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;
  logic          rd_ok_q, rd_ok_d;  // read address was in range
  logic [16:0]   rd_pos;            // side offset to read this cycle
  logic [19:0]   rd_idx;

  ddrb_store #(.Depth(Depth), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (req_q.image_index[AW-1:0]),
    .wdata_i (req_q.write_data),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  logic [7:0] rd_byte;
  assign rd_byte = rd_ok_q ? st_rdata : 8'd0;

  assign rd_idx   = 20'(cur_side_q) * 20'(SideSize) + 20'(rd_pos);
  assign st_raddr = rd_idx[AW-1:0];
  assign st_we    = (state_q == S_EXEC) && (req_q.req_type == ddrb_pkg::REQ_LOAD) &&
                    (32'(req_q.image_index) < 32'(Depth));

  // APB configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_side_q <= '0;
      inserted_q <= 1'b1;
      present_q  <= 1'b0;
      cps_q      <= 10'd114;
      cpb_q      <= 10'd149;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ddrb_pkg::CFG_SIDE:     cur_side_q <= pwdata[1:0];
        ddrb_pkg::CFG_INSERTED: inserted_q <= pwdata[0];
        ddrb_pkg::CFG_PRESENT:  present_q  <= pwdata[0];
        ddrb_pkg::CFG_CPS:      cps_q      <= pwdata[9:0];
        ddrb_pkg::CFG_CPB:      cpb_q      <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      ddrb_pkg::CFG_SIDE:     prdata = 32'(cur_side_q);
      ddrb_pkg::CFG_INSERTED: prdata = 32'(inserted_q);
      ddrb_pkg::CFG_PRESENT:  prdata = 32'(present_q);
      ddrb_pkg::CFG_CPS:      prdata = 32'(cps_q);
      ddrb_pkg::CFG_CPB:      prdata = 32'(cpb_q);
      default:                prdata = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Shared helpers.
  logic [9:0]  per;
  logic        stream_on;
  logic [16:0] sz_raw, sz_clip, pos_plus;
  logic [16:0] side_left;
  assign per       = (cpb_q == 10'd0) ? 10'd1 : cpb_q;
  assign stream_on = motor_q && !xrst_q && scan_q && rmode_q && inserted_q &&
                     present_q && (phase_q != ddrb_pkg::PH_IDLE);
  assign side_left = 17'(SideSize) - 17'(pos_q);
  assign pos_plus  = 17'(pos_q) + 17'd14;

  always_comb begin
    case (ebtype_q)
      8'd1:    sz_raw = 17'd56;
      8'd2:    sz_raw = 17'd2;
      8'd3:    sz_raw = 17'd16;
      default: sz_raw = 17'd1 + 17'(nds_q);
    endcase
    sz_clip = (sz_raw > side_left) ? side_left : sz_raw;
  end

  always_comb begin
    state_d = state_q; req_d = req_q; rsp_d = rsp_q; done_d = 1'b0; eb_ret_d = eb_ret_q;
    reload_d = reload_q; count_d = count_q; t_en_d = t_en_q; t_rep_d = t_rep_q;
    t_pend_d = t_pend_q; master_d = master_q; motor_d = motor_q; xrst_d = xrst_q;
    rmode_d = rmode_q; b_en_d = b_en_q; scan_d = scan_q; pos_d = pos_q;
    bstart_d = bstart_q; rbuf_d = rbuf_q; b_pend_d = b_pend_q; eoh_d = eoh_q;
    acc_d = acc_q; spin_d = spin_q; staged_d = staged_q; phase_d = phase_q;
    brem_d = brem_q; crem_d = crem_q; nds_d = nds_q; trem_d = trem_q;
    ebtype_d = ebtype_q; b13_d = b13_q;
    rd_pos = 17'(pos_q);
    rd_ok_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          rsp_d   = '0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        case (req_q.req_type)
          ddrb_pkg::REQ_WRITE: begin
            case (req_q.bus_addr)
              ddrb_pkg::ADDR_RELOAD_LO: reload_d[7:0]  = req_q.write_data;
              ddrb_pkg::ADDR_RELOAD_HI: reload_d[15:8] = req_q.write_data;
              ddrb_pkg::ADDR_TIMER_CTL: begin
                t_rep_d = req_q.write_data[0];
                t_en_d  = req_q.write_data[1];
                if (req_q.write_data[1]) count_d = reload_q;
                else t_pend_d = 1'b0;
              end
              ddrb_pkg::ADDR_MASTER: begin
                master_d = req_q.write_data[1:0];
                if (!req_q.write_data[0]) begin
                  t_pend_d = 1'b0;
                  b_pend_d = 1'b0;
                end
              end
              ddrb_pkg::ADDR_WDATA: begin
                staged_d = req_q.write_data;
                b_pend_d = 1'b0;
              end
              ddrb_pkg::ADDR_CONTROL: begin
                rsp_d.mirror_valid  = 1'b1;
                rsp_d.mirror_select = !req_q.write_data[3];
                motor_d = req_q.write_data[0];
                xrst_d  = req_q.write_data[1];
                rmode_d = req_q.write_data[2];
                scan_d  = req_q.write_data[6];
                b_en_d  = req_q.write_data[7];
                if (!motor_q && req_q.write_data[0]) begin
                  pos_d = '0; bstart_d = '0; acc_d = '0; eoh_d = 1'b0;
                  phase_d = ddrb_pkg::PH_IDLE; brem_d = '0; crem_d = '0; nds_d = '0;
                  spin_d = ddrb_pkg::SPINUP_TICKS;
                end
                if (!xrst_q && req_q.write_data[1]) begin
                  phase_d = ddrb_pkg::PH_IDLE;
                  pos_d   = (!motor_q && req_q.write_data[0]) ? 16'd0 : bstart_q;
                end
                if (xrst_q && !req_q.write_data[1]) begin
                  // Motor start may have cleared position: parse from the new one.
                  acc_d    = '0;
                  eb_ret_d = 1'b0;
                  state_d  = S_EB;
                end
              end
              default: ;
            endcase
          end
          ddrb_pkg::REQ_READ: begin
            case (req_q.bus_addr)
              ddrb_pkg::ADDR_STATUS: begin
                rsp_d.read_data = {1'b0, eoh_q, 4'd0, b_pend_q, t_pend_q};
                t_pend_d = 1'b0;
                b_pend_d = 1'b0;
              end
              ddrb_pkg::ADDR_RDATA: begin
                rsp_d.read_data = rbuf_q;
                b_pend_d = 1'b0;
              end
              ddrb_pkg::ADDR_DRIVE: begin
                if (!inserted_q) rsp_d.read_data = 8'h05;
                else if (!motor_q || spin_q != 6'd0) rsp_d.read_data = 8'h02;
                else rsp_d.read_data = 8'h00;
              end
              ddrb_pkg::ADDR_EXT: rsp_d.read_data = 8'h80;
              default: rsp_d.read_data = req_q.bus_addr[15:8];
            endcase
          end
          ddrb_pkg::REQ_TICK: begin
            trem_d  = cps_q;
            state_d = S_TIMER;
          end
          default: ;  // image load writes the store directly
        endcase
      end

      // One timer expiry or the final countdown per cycle.
      S_TIMER: begin
        if (!(t_en_q && master_q[0]) || trem_q == 10'd0) begin
          state_d = S_SPIN;
        end else if (count_q <= 16'(trem_q)) begin
          trem_d   = trem_q - count_q[9:0];
          t_pend_d = 1'b1;
          if (t_rep_q) begin
            count_d = reload_q;
            if (reload_q == 16'd0) state_d = S_SPIN;
          end else begin
            t_en_d  = 1'b0;
            count_d = '0;
            state_d = S_SPIN;
          end
        end else begin
          count_d = count_q - 16'(trem_q);
          trem_d  = '0;
          state_d = S_SPIN;
        end
      end

      S_SPIN: begin
        if (spin_q != 6'd0) begin
          spin_d  = spin_q - 6'd1;
          state_d = S_DONE;
        end else if (stream_on) begin
          acc_d   = acc_q + 11'(cps_q);
          state_d = S_BYTE;
        end else begin
          state_d = S_DONE;
        end
      end

      // Produce one byte per pass while the accumulator covers a byte period.
      S_BYTE: begin
        if (acc_q < 11'(per)) begin
          state_d = S_DONE;
        end else begin
          acc_d    = acc_q - 11'(per);
          b_pend_d = 1'b1;
          case (phase_q)
            ddrb_pkg::PH_BLOCK: begin
              rd_pos  = 17'(pos_q);
              rd_ok_d = (32'(cur_side_q) * 32'(SideSize) + 32'(pos_q)) < 32'(Depth);
              pos_d   = pos_q + 16'd1;
              if (brem_q <= 17'd1) begin
                brem_d  = '0;
                phase_d = ddrb_pkg::PH_CRC;
                crem_d  = 2'd2;
              end else begin
                brem_d = brem_q - 17'd1;
              end
              state_d = S_BRD;
            end
            ddrb_pkg::PH_CRC: begin
              rbuf_d = '0;
              if (crem_q <= 2'd1) begin
                crem_d   = '0;
                eb_ret_d = 1'b1;
                state_d  = S_EB;
              end else begin
                crem_d = crem_q - 2'd1;
              end
            end
            default: rbuf_d = '0;
          endcase
        end
      end

      S_BRD: begin
        rbuf_d  = rd_byte;
        state_d = S_BYTE;
      end

      S_EB: begin
        if (32'(pos_q) >= 32'(SideSize)) begin
          eoh_d   = 1'b1;
          phase_d = ddrb_pkg::PH_END;
          state_d = eb_ret_q ? S_BYTE : S_DONE;
        end else begin
          rd_pos  = 17'(pos_q);
          rd_ok_d = (32'(cur_side_q) * 32'(SideSize) + 32'(pos_q)) < 32'(Depth);
          state_d = S_EBT;
        end
      end

      S_EBT: begin
        ebtype_d = rd_byte;
        if (rd_byte == 8'd3) begin
          if (32'(pos_plus) < 32'(SideSize)) begin
            rd_pos  = 17'(pos_q) + 17'd13;
            rd_ok_d = (32'(cur_side_q) * 32'(SideSize) + 32'(pos_q) + 32'd13) < 32'(Depth);
            state_d = S_EB13;
          end else begin
            nds_d   = '0;
            state_d = S_EBSZ;
          end
        end else if (rd_byte inside {[8'd1:8'd4]}) begin
          state_d = S_EBSZ;
        end else begin
          eoh_d   = 1'b1;
          phase_d = ddrb_pkg::PH_END;
          state_d = eb_ret_q ? S_BYTE : S_DONE;
        end
      end

      S_EB13: begin
        b13_d   = rd_byte;
        rd_pos  = pos_plus;
        rd_ok_d = (32'(cur_side_q) * 32'(SideSize) + 32'(pos_plus)) < 32'(Depth);
        state_d = S_EB14;
      end

      S_EB14: begin
        nds_d   = {rd_byte, b13_q};
        state_d = S_EBSZ;
      end

      S_EBSZ: begin
        brem_d   = sz_clip;
        bstart_d = pos_q;
        phase_d  = ddrb_pkg::PH_BLOCK;
        state_d  = eb_ret_q ? S_BYTE : S_DONE;
      end

      S_DONE: begin
        if (req_q.req_type == ddrb_pkg::REQ_TICK) begin
          rsp_d.irq_line = master_q[0] && (t_pend_q || (b_pend_q && b_en_q));
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; done_q <= 1'b0; eb_ret_q <= 1'b0;
      reload_q <= '0; count_q <= '0; t_en_q <= 1'b0; t_rep_q <= 1'b0; t_pend_q <= 1'b0;
      master_q <= '0; motor_q <= 1'b0; xrst_q <= 1'b1; rmode_q <= 1'b1;
      b_en_q <= 1'b0; scan_q <= 1'b0; pos_q <= '0; bstart_q <= '0; rbuf_q <= '0;
      b_pend_q <= 1'b0; eoh_q <= 1'b0; acc_q <= '0; spin_q <= '0; staged_q <= '0;
      phase_q <= ddrb_pkg::PH_IDLE; brem_q <= '0; crem_q <= '0; nds_q <= '0;
      rd_ok_q <= 1'b0; rsp_q <= '0;
    end else begin
      state_q <= state_d; done_q <= done_d; eb_ret_q <= eb_ret_d;
      reload_q <= reload_d; count_q <= count_d; t_en_q <= t_en_d; t_rep_q <= t_rep_d;
      t_pend_q <= t_pend_d; master_q <= master_d; motor_q <= motor_d; xrst_q <= xrst_d;
      rmode_q <= rmode_d; b_en_q <= b_en_d; scan_q <= scan_d; pos_q <= pos_d;
      bstart_q <= bstart_d; rbuf_q <= rbuf_d; b_pend_q <= b_pend_d; eoh_q <= eoh_d;
      acc_q <= acc_d; spin_q <= spin_d; staged_q <= staged_d; phase_q <= phase_d;
      brem_q <= brem_d; crem_q <= crem_d; nds_q <= nds_d;
      rd_ok_q <= rd_ok_d; rsp_q <= rsp_d;
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    trem_q   <= trem_d;
    ebtype_q <= ebtype_d;
    b13_q    <= b13_d;
  end

endmodule

[sv/ddrb_store.sv]
// Disk image store: one write port, one registered read port.
module ddrb_store #(
  parameter int Depth = 262000,
  parameter int AW    = 18
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[bench/disk_drive_register_block_top_tb.sv]
// Self-checking testbench for the disk drive register block top level.
module disk_drive_register_block_top_tb;

  localparam int unsigned SideSize   = 65500;
  localparam int unsigned StoreDepth = 4 * SideSize;
  // Disk images sit at the head of each side; keep noise loads out of this window.
  localparam int unsigned ImageSpan  = 128;
  localparam int unsigned StallLimit = 40000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  logic           busy_o;
  ddrb_pkg::req_t req_i = '0;
  logic           done_o;
  ddrb_pkg::rsp_t rsp_o;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [4:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  disk_drive_register_block_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the drive: configuration, register state and the disk image.
  logic [7:0]  disk_img [0:StoreDepth-1];
  logic [1:0]  cur_side;
  logic        inserted, present;
  logic [9:0]  cps, cpb;
  logic [15:0] tmr_reload, tmr_count;
  logic        tmr_irq_en, tmr_repeat, tmr_pend;
  logic [1:0]  master_en;
  logic        motor_on, xfer_rst, read_mode, byte_irq_en, scan_en;
  logic [15:0] strm_pos, blk_start, next_size;
  logic [7:0]  rd_buf, staged;
  logic        byte_pend, end_head;
  logic [10:0] byte_accum;
  logic [5:0]  spinup_cnt;
  logic [1:0]  phase;
  logic [16:0] blk_left;
  logic [1:0]  crc_left;

  ddrb_pkg::req_t cmd_q[$];
  ddrb_pkg::rsp_t rsp_expect_q[$];
  int   n_words = 0;
  int   n_results = 0;
  int   n_fail = 0;
  int   n_ticks = 0;
  int   n_irq = 0;
  int   idle_cnt = 0;

  function automatic void drive_reset();
    cur_side = 2'd0; inserted = 1'b1; present = 1'b0; cps = 10'd114; cpb = 10'd149;
    tmr_reload = 16'd0; tmr_count = 16'd0; tmr_irq_en = 1'b0; tmr_repeat = 1'b0;
    tmr_pend = 1'b0; master_en = 2'd0; motor_on = 1'b0; xfer_rst = 1'b1; read_mode = 1'b1;
    byte_irq_en = 1'b0; scan_en = 1'b0; strm_pos = 16'd0; blk_start = 16'd0;
    rd_buf = 8'd0; byte_pend = 1'b0; end_head = 1'b0; byte_accum = 11'd0;
    spinup_cnt = 6'd0; staged = 8'd0; phase = ddrb_pkg::PH_IDLE;
    blk_left = 17'd0; crc_left = 2'd0; next_size = 16'd0;
  endfunction

  function automatic logic [7:0] disk_byte(int unsigned pos);
    int unsigned idx;
    idx = 32'(cur_side) * SideSize + pos;
    return (idx < StoreDepth) ? disk_img[idx] : 8'h00;
  endfunction

  // Parse the block header at the current position and arm the stream.
  function automatic void open_block();
    int unsigned p, len;
    p = 32'(strm_pos);
    if (p >= SideSize) begin
      end_head = 1'b1; phase = ddrb_pkg::PH_END;
      return;
    end
    case (disk_byte(p))
      8'd1: len = 56;
      8'd2: len = 2;
      8'd3: begin
        len = 16;
        if (p + 14 < SideSize) next_size = {disk_byte(p + 14), disk_byte(p + 13)};
        else next_size = 16'd0;
      end
      8'd4: len = 1 + 32'(next_size);
      default: begin
        end_head = 1'b1; phase = ddrb_pkg::PH_END;
        return;
      end
    endcase
    if (p + len > SideSize) len = SideSize - p;
    blk_left = 17'(len);
    blk_start = strm_pos;
    phase = ddrb_pkg::PH_BLOCK;
  endfunction

  function automatic logic [7:0] next_stream_byte();
    logic [7:0] b;
    if (phase == ddrb_pkg::PH_BLOCK) begin
      b = disk_byte(32'(strm_pos));
      strm_pos = strm_pos + 16'd1;
      if (blk_left <= 17'd1) begin
        blk_left = 17'd0; phase = ddrb_pkg::PH_CRC; crc_left = 2'd2;
      end else begin
        blk_left = blk_left - 17'd1;
      end
      return b;
    end
    if (phase == ddrb_pkg::PH_CRC) begin
      if (crc_left <= 2'd1) begin
        crc_left = 2'd0;
        open_block();
      end else begin
        crc_left = crc_left - 2'd1;
      end
    end
    return 8'h00;
  endfunction

  function automatic void bus_write(logic [15:0] addr, logic [7:0] d);
    logic motor_was, rst_was;
    case (addr)
      ddrb_pkg::ADDR_RELOAD_LO: tmr_reload[7:0] = d;
      ddrb_pkg::ADDR_RELOAD_HI: tmr_reload[15:8] = d;
      ddrb_pkg::ADDR_TIMER_CTL: begin
        tmr_repeat = d[0];
        tmr_irq_en = d[1];
        if (tmr_irq_en) tmr_count = tmr_reload;
        else tmr_pend = 1'b0;
      end
      ddrb_pkg::ADDR_MASTER: begin
        master_en = d[1:0];
        if (!master_en[0]) begin
          tmr_pend = 1'b0; byte_pend = 1'b0;
        end
      end
      ddrb_pkg::ADDR_WDATA: begin
        staged = d; byte_pend = 1'b0;
      end
      ddrb_pkg::ADDR_CONTROL: begin
        motor_was = motor_on; rst_was = xfer_rst;
        motor_on = d[0]; xfer_rst = d[1]; read_mode = d[2];
        scan_en = d[6]; byte_irq_en = d[7];
        if (!motor_was && motor_on) begin
          strm_pos = 16'd0; blk_start = 16'd0; byte_accum = 11'd0; end_head = 1'b0;
          phase = ddrb_pkg::PH_IDLE; blk_left = 17'd0; crc_left = 2'd0;
          next_size = 16'd0; spinup_cnt = ddrb_pkg::SPINUP_TICKS;
        end
        if (!rst_was && xfer_rst) begin
          phase = ddrb_pkg::PH_IDLE; strm_pos = blk_start;
        end
        if (rst_was && !xfer_rst) begin
          open_block();
          byte_accum = 11'd0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] bus_read(logic [15:0] addr);
    logic [7:0] r;
    r = 8'h00;
    case (addr)
      ddrb_pkg::ADDR_STATUS: begin
        r = {1'b0, end_head, 4'b0, byte_pend, tmr_pend};
        tmr_pend = 1'b0; byte_pend = 1'b0;
      end
      ddrb_pkg::ADDR_RDATA: begin
        byte_pend = 1'b0; r = rd_buf;
      end
      ddrb_pkg::ADDR_DRIVE: begin
        if (!inserted) r = 8'h05;
        else if (!motor_on || spinup_cnt > 6'd0) r = 8'h02;
      end
      ddrb_pkg::ADDR_EXT: r = 8'h80;
      default: r = addr[15:8];
    endcase
    return r;
  endfunction

  function automatic logic scanline_tick();
    int unsigned left, per, acc;
    if (tmr_irq_en && master_en[0]) begin
      left = 32'(cps);
      while (left > 0 && tmr_irq_en) begin
        if (32'(tmr_count) <= left) begin
          left = left - 32'(tmr_count);
          tmr_pend = 1'b1;
          if (tmr_repeat) begin
            tmr_count = tmr_reload;
            if (tmr_reload == 16'd0) break;
          end else begin
            tmr_irq_en = 1'b0; tmr_count = 16'd0;
          end
        end else begin
          tmr_count = tmr_count - left[15:0];
          left = 0;
        end
      end
    end
    if (spinup_cnt > 6'd0) begin
      spinup_cnt = spinup_cnt - 6'd1;
    end else if (motor_on && !xfer_rst && scan_en && read_mode && inserted && present &&
                 phase != ddrb_pkg::PH_IDLE) begin
      per = (cpb == 10'd0) ? 32'd1 : 32'(cpb);
      acc = 32'(byte_accum) + 32'(cps);
      while (acc >= per) begin
        acc = acc - per;
        rd_buf = next_stream_byte();
        byte_pend = 1'b1;
      end
      byte_accum = 11'(acc);
    end
    return master_en[0] && (tmr_pend || (byte_pend && byte_irq_en));
  endfunction

  function automatic ddrb_pkg::rsp_t predict_word(ddrb_pkg::req_t r);
    ddrb_pkg::rsp_t o;
    o = '0;
    case (r.req_type)
      ddrb_pkg::REQ_WRITE: begin
        bus_write(r.bus_addr, r.write_data);
        if (r.bus_addr == ddrb_pkg::ADDR_CONTROL) begin
          o.mirror_valid = 1'b1;
          o.mirror_select = !r.write_data[3];
        end
      end
      ddrb_pkg::REQ_READ: o.read_data = bus_read(r.bus_addr);
      ddrb_pkg::REQ_TICK: o.irq_line = scanline_tick();
      default: if (32'(r.image_index) < StoreDepth) disk_img[r.image_index] = r.write_data;
    endcase
    return o;
  endfunction

  // Driver: issue words from the pending queue, with random gaps outside the quiet window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        rsp_expect_q.push_back(predict_word(req_i));
        n_words++;
        if (req_i.req_type == ddrb_pkg::REQ_TICK) n_ticks++;
      end
      if (!start_i || !busy_o) begin
        if (cmd_q.size() > 0 &&
            ((n_words > 400 && n_words < 600) || $urandom_range(99) >= 32)) begin
          start_i <= 1'b1;
          req_i <= cmd_q.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every strobed result with the oldest prediction.
  always @(posedge clk_i) begin
    ddrb_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (rsp_o.irq_line) n_irq++;
      if (rsp_expect_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, rsp_o);
        n_fail++;
      end else begin
        want = rsp_expect_q.pop_front();
        if (rsp_o.read_data !== want.read_data || rsp_o.irq_line !== want.irq_line ||
            rsp_o.mirror_valid !== want.mirror_valid ||
            rsp_o.mirror_select !== want.mirror_select) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, rsp_o);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  function automatic ddrb_pkg::req_t mk(logic [1:0] kind, logic [15:0] addr, logic [7:0] d,
                                        logic [17:0] idx);
    ddrb_pkg::req_t r;
    r.req_type = kind; r.bus_addr = addr; r.write_data = d; r.image_index = idx;
    return r;
  endfunction

  function automatic void push_load(int unsigned idx, logic [7:0] d);
    cmd_q.push_back(mk(ddrb_pkg::REQ_LOAD, 16'($urandom), d, idx[17:0]));
  endfunction

  // Well-formed side image: type 1, 2, 3 and 4 blocks, then a bad type byte to stop.
  function automatic void push_image(int unsigned side);
    int unsigned base, len4, p;
    base = side * SideSize;
    len4 = $urandom_range(0, 20);
    push_load(base, 8'd1);
    for (p = 1; p < 56; p++) push_load(base + p, 8'($urandom));
    push_load(base + 56, 8'd2);
    push_load(base + 57, 8'($urandom));
    push_load(base + 58, 8'd3);
    for (p = 59; p < 74; p++) begin
      if (p == 71) push_load(base + p, len4[7:0]);
      else if (p == 72) push_load(base + p, 8'h00);
      else push_load(base + p, 8'($urandom));
    end
    push_load(base + 74, 8'd4);
    for (p = 75; p < 75 + len4; p++) push_load(base + p, 8'($urandom));
    push_load(base + 75 + len4, $urandom_range(0, 1) ? 8'h00 : 8'hFF);
  endfunction

  function automatic logic [7:0] control_byte();
    if ($urandom_range(99) < 15) return 8'($urandom);
    return 8'h45 | {$urandom_range(0, 1) == 1, 3'b0, 4'($urandom_range(0, 15)) & 4'h8} |
           (($urandom_range(99) < 10) ? 8'h02 : 8'h00) | (8'($urandom) & 8'h30);
  endfunction

  function automatic ddrb_pkg::req_t random_word();
    int unsigned pick;
    logic [15:0] a;
    logic [7:0] d;
    pick = $urandom_range(99);
    d = 8'($urandom);
    if (pick < 35) return mk(ddrb_pkg::REQ_TICK, 16'($urandom), d, 18'($urandom));
    if (pick < 60) begin
      case ($urandom_range(5))
        0: a = ddrb_pkg::ADDR_STATUS;
        1: a = ddrb_pkg::ADDR_RDATA;
        2: a = ddrb_pkg::ADDR_DRIVE;
        3: a = ddrb_pkg::ADDR_EXT;
        4: a = ddrb_pkg::ADDR_RELOAD_LO + 16'($urandom_range(31));
        default: a = 16'($urandom);
      endcase
      return mk(ddrb_pkg::REQ_READ, a, d, 18'($urandom));
    end
    if (pick < 88) begin
      case ($urandom_range(7))
        0: a = ddrb_pkg::ADDR_RELOAD_LO;
        1: begin
          a = ddrb_pkg::ADDR_RELOAD_HI;
          if ($urandom_range(1)) d = 8'h00;
        end
        2: a = ddrb_pkg::ADDR_TIMER_CTL;
        3: begin
          a = ddrb_pkg::ADDR_MASTER;
          if ($urandom_range(3)) d[0] = 1'b1;
        end
        4: a = ddrb_pkg::ADDR_WDATA;
        5: begin
          a = ddrb_pkg::ADDR_CONTROL;
          d = control_byte();
        end
        6: a = ddrb_pkg::ADDR_CONTROL + 16'd1 + 16'($urandom_range(9));
        default: a = 16'($urandom);
      endcase
      return mk(ddrb_pkg::REQ_WRITE, a, d, 18'($urandom));
    end
    // Noise loads stay clear of the image head, or fall off the end of the store.
    if ($urandom_range(3) == 0)
      return mk(ddrb_pkg::REQ_LOAD, 16'($urandom), d,
                18'($urandom_range(StoreDepth, 262143)));
    return mk(ddrb_pkg::REQ_LOAD, 16'($urandom), d,
              18'($urandom_range(3) * SideSize + $urandom_range(ImageSpan, SideSize - 1)));
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ddrb_pkg::CFG_SIDE:     cur_side = val[1:0];
      ddrb_pkg::CFG_INSERTED: inserted = val[0];
      ddrb_pkg::CFG_PRESENT:  present = val[0];
      ddrb_pkg::CFG_CPS:      cps = val[9:0];
      default:                cpb = val[9:0];
    endcase
  endtask

  // Wait on settled values until every queued word has been accepted and answered.
  task automatic drain();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || start_i || busy_o || rsp_expect_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Settings per phase: side, inserted, present, cycles per tick, cycles per byte, words.
  int unsigned plan [8][6] = '{
    '{0, 1, 1, 114, 149, 140}, '{1, 1, 1, 1023, 1, 30}, '{2, 1, 1, 1, 1023, 80},
    '{3, 0, 1, 0, 0, 60},      '{3, 1, 1, 500, 0, 80},  '{1, 1, 0, 114, 149, 60},
    '{0, 1, 1, 300, 37, 130},  '{2, 1, 1, 1023, 1023, 90}
  };

  initial begin
    int unsigned ph, k;
    drive_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load an image on every side before anything can parse a header.
    for (k = 0; k < 4; k++) push_image(k);
    // Directed words: register extremes, open bus, unmapped writes, store edges.
    cmd_q.push_back(mk(ddrb_pkg::REQ_READ, ddrb_pkg::ADDR_DRIVE, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_RELOAD_LO, 8'hFF, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_RELOAD_HI, 8'hFF, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_TIMER_CTL, 8'h03, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_MASTER, 8'h03, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_TICK, 16'h0000, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_RELOAD_LO, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_RELOAD_HI, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_TIMER_CTL, 8'h03, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_TICK, 16'hFFFF, 8'hFF, 18'h3FFFF));
    cmd_q.push_back(mk(ddrb_pkg::REQ_READ, ddrb_pkg::ADDR_STATUS, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_WDATA, 8'hA5, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_CONTROL, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_CONTROL, 8'hFF, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_CONTROL, 8'hC5, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_CONTROL + 16'd1, 8'h5A, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, 16'hFFFF, 8'hFF, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_READ, ddrb_pkg::ADDR_RDATA, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_READ, ddrb_pkg::ADDR_DRIVE, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_READ, ddrb_pkg::ADDR_EXT, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_READ, 16'h0000, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_READ, 16'hFFFF, 8'h00, '0));
    cmd_q.push_back(mk(ddrb_pkg::REQ_LOAD, 16'h0000, 8'hFF, 18'h3FFFF));
    cmd_q.push_back(mk(ddrb_pkg::REQ_LOAD, 16'hFFFF, 8'h00, 18'(StoreDepth)));
    cmd_q.push_back(mk(ddrb_pkg::REQ_LOAD, 16'h0000, 8'h81, 18'(StoreDepth - 1)));
    drain();

    for (ph = 0; ph < 8; ph++) begin
      // Stop the motor and hold the transfer reset so a side change parses nothing.
      cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_CONTROL, 8'h02, '0));
      drain();
      cfg_write(ddrb_pkg::CFG_SIDE, plan[ph][0]);
      cfg_write(ddrb_pkg::CFG_INSERTED, plan[ph][1]);
      cfg_write(ddrb_pkg::CFG_PRESENT, plan[ph][2]);
      cfg_write(ddrb_pkg::CFG_CPS, plan[ph][3]);
      cfg_write(ddrb_pkg::CFG_CPB, plan[ph][4]);
      // Spin the motor up from rest and release the transfer reset, then mix words.
      cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_MASTER,
                         8'h01 | 8'($urandom_range(1) << 1), '0));
      cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_RELOAD_LO, 8'($urandom), '0));
      cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_RELOAD_HI, 8'h00, '0));
      cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_TIMER_CTL,
                         8'($urandom_range(3)), '0));
      cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_CONTROL, 8'h07, '0));
      cmd_q.push_back(mk(ddrb_pkg::REQ_WRITE, ddrb_pkg::ADDR_CONTROL,
                         control_byte() & 8'hFD, '0));
      for (k = 0; k < plan[ph][5]; k++) cmd_q.push_back(random_word());
      drain();
    end

    $display("Covered %0d words (%0d ticks) over 8 drive settings plus directed cases;",
             n_words, n_ticks);
    $display("checked %0d result words, %0d with the interrupt line raised.", n_results, n_irq);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
